// ===== design/saq_pkg.sv =====
// ----------------------------------------------------------------------------
// saq_pkg
// Shared types and constants for the sorted alarm queue.
// ----------------------------------------------------------------------------
package saq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ADDR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W       = ADDR_W + 1;
  localparam int ENTRY_W     = 64;

  typedef enum logic [1:0] {
    KIND_ACCEPTED = 2'd0,
    KIND_FULL     = 2'd1,
    KIND_FIRED    = 2'd2
  } kind_e;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_TICK   = 1'b1
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_READ,
    ST_INS_CMP,
    ST_SH_READ,
    ST_SH_WRITE,
    ST_TK_HEAD,
    ST_TK_LOAD,
    ST_TK_CHECK
  } state_t;

  typedef struct packed {
    logic        action;
    logic [15:0] delay_seconds;
    logic [15:0] tag;
  } alarm_cmd_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] fired_delay;
    logic [15:0] fired_tag;
    logic        last;
  } alarm_result_t;

  typedef struct packed {
    logic [31:0] expiry;
    logic [15:0] delay;
    logic [15:0] tag;
  } alarm_entry_t;

  // a is at or before b in wrapping time order
  function automatic logic not_after(logic [31:0] a, logic [31:0] b);
    logic [31:0] diff;
    diff = b - a;
    return ~diff[31];
  endfunction

endpackage

// ===== design/saq_ram.sv =====
// ----------------------------------------------------------------------------
// saq_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module saq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/sorted_alarm_queue_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_alarm_queue_unit
// Alarm queue sorted by expiry, with one pending slot in front of it.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Each result is
// shown for one cycle with result_valid and cannot be held off. An insert
// walks the ring buffer in RAM through one read port: each entry searched
// takes a read and a compare state, each entry shifted a read and a write
// state; busy stays high until the new alarm is written, and the result
// follows. A table-full insert answers in the cycle after it is taken. A tick
// goes through a head state, a load state when a head is moved into the
// pending slot (RAM read latency), and a check state, and goes round again
// for each alarm that fires.
// ----------------------------------------------------------------------------
module sorted_alarm_queue_unit
  import saq_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  alarm_cmd_t    cmd,
  output logic          busy,
  output logic          result_valid,
  output alarm_result_t result
);

  state_t             state, state_next;
  logic [31:0]        now_ctr, now_ctr_next;
  logic [ADDR_W-1:0]  head, head_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [CNT_W-1:0]   idx, idx_next;
  logic [CNT_W-1:0]   pos, pos_next;
  alarm_entry_t       new_entry, new_entry_next;
  alarm_entry_t       pend, pend_next;
  logic               pend_valid, pend_valid_next;
  alarm_entry_t       hold, hold_next;
  logic               hold_valid, hold_valid_next;
  logic               result_valid_next;
  alarm_result_t      result_next;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  alarm_entry_t       ram_wdata, ram_rdata;
  logic [ENTRY_W-1:0] ram_rdata_raw;

  logic               accept;
  logic               fire_now;
  logic               ins_hit;

  function automatic logic [ADDR_W-1:0] ring(logic [ADDR_W-1:0] base,
                                             logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(QUEUE_DEPTH)) begin
      sum = sum - SUM_W'(QUEUE_DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

  saq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata_raw)
  );

  assign ram_rdata = alarm_entry_t'(ram_rdata_raw);
  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign fire_now  = pend_valid && not_after(pend.expiry, now_ctr);
  assign ins_hit   = not_after(new_entry.expiry, ram_rdata.expiry);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (cmd.action == ACT_TICK) begin
            state_next = ST_TK_HEAD;
          end else if (count != CNT_W'(QUEUE_DEPTH)) begin
            state_next = ST_INS_READ;
          end
        end
      end
      ST_INS_READ: state_next = (idx == count) ? ST_SH_READ : ST_INS_CMP;
      ST_INS_CMP:  state_next = ins_hit ? ST_SH_READ : ST_INS_READ;
      ST_SH_READ:  state_next = (idx == pos) ? ST_IDLE : ST_SH_WRITE;
      ST_SH_WRITE: state_next = ST_SH_READ;
      ST_TK_HEAD: begin
        if (!pend_valid && count != '0) begin
          state_next = ST_TK_LOAD;
        end else begin
          state_next = ST_TK_CHECK;
        end
      end
      ST_TK_LOAD:  state_next = ST_TK_CHECK;
      ST_TK_CHECK: state_next = fire_now ? ST_TK_HEAD : ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    now_ctr_next      = now_ctr;
    head_next         = head;
    count_next        = count;
    idx_next          = idx;
    pos_next          = pos;
    new_entry_next    = new_entry;
    pend_next         = pend;
    pend_valid_next   = pend_valid;
    hold_next         = hold;
    hold_valid_next   = hold_valid;
    result_valid_next = 1'b0;
    result_next       = result;
    ram_we            = 1'b0;
    ram_waddr         = ring(head, idx);
    ram_wdata         = ram_rdata;
    ram_raddr         = ring(head, idx);
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (cmd.action == ACT_TICK) begin
            now_ctr_next = now_ctr + 32'd1;
          end else if (count == CNT_W'(QUEUE_DEPTH)) begin
            result_valid_next = 1'b1;
            result_next       = '{kind: KIND_FULL, fired_delay: '0,
                                  fired_tag: '0, last: 1'b1};
          end else begin
            new_entry_next = '{expiry: now_ctr + 32'(cmd.delay_seconds),
                               delay: cmd.delay_seconds, tag: cmd.tag};
            idx_next       = '0;
          end
        end
      end
      ST_INS_READ: begin
        // end of the walk: append at the tail
        if (idx == count) begin
          pos_next = count;
        end
      end
      ST_INS_CMP: begin
        if (ins_hit) begin
          pos_next = idx;
          idx_next = count;
        end else begin
          idx_next = idx + CNT_W'(1);
        end
      end
      ST_SH_READ: begin
        if (idx == pos) begin
          ram_we            = 1'b1;
          ram_wdata         = new_entry;
          count_next        = count + CNT_W'(1);
          result_valid_next = 1'b1;
          result_next       = '{kind: KIND_ACCEPTED, fired_delay: '0,
                                fired_tag: '0, last: 1'b1};
        end else begin
          ram_raddr = ring(head, idx - CNT_W'(1));
        end
      end
      ST_SH_WRITE: begin
        ram_we   = 1'b1;
        idx_next = idx - CNT_W'(1);
      end
      ST_TK_HEAD: begin
        ram_raddr = head;
      end
      ST_TK_LOAD: begin
        pend_next       = ram_rdata;
        pend_valid_next = 1'b1;
        head_next       = (head == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : head + ADDR_W'(1);
        count_next      = count - CNT_W'(1);
      end
      ST_TK_CHECK: begin
        // a fired alarm is held back until we know whether the next one fires
        if (hold_valid) begin
          result_valid_next = 1'b1;
          result_next       = '{kind: KIND_FIRED, fired_delay: hold.delay,
                                fired_tag: hold.tag, last: !fire_now};
        end
        hold_valid_next = fire_now;
        if (fire_now) begin
          hold_next       = pend;
          pend_valid_next = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      now_ctr      <= '0;
      head         <= '0;
      count        <= '0;
      pend_valid   <= 1'b0;
      hold_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      now_ctr      <= now_ctr_next;
      head         <= head_next;
      count        <= count_next;
      pend_valid   <= pend_valid_next;
      hold_valid   <= hold_valid_next;
      result_valid <= result_valid_next;
    end
    idx       <= idx_next;
    pos       <= pos_next;
    new_entry <= new_entry_next;
    pend      <= pend_next;
    hold      <= hold_next;
    result    <= result_next;
  end

endmodule

// ===== tb/saq_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// saq_checker
// Watches the command and result channels of the sorted alarm queue, keeps
// its own copy of the queue state and compares every result in order.
// ----------------------------------------------------------------------------
module saq_checker
  import saq_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          busy,
  input  alarm_cmd_t    cmd,
  input  logic          result_valid,
  input  alarm_result_t result,
  output int unsigned   error_count,
  output int unsigned   pending_results
);

  logic [31:0]   now_ticks;
  alarm_entry_t  model_queue [QUEUE_DEPTH];
  int            alarm_count;
  alarm_entry_t  staged_alarm;
  bit            staged_valid;
  alarm_result_t predicted_outcomes [$];
  int unsigned   mismatches;

  assign error_count = mismatches;

  initial mismatches = 0;

  // serial time order: a at or before b
  function automatic bit is_due(logic [31:0] a, logic [31:0] b);
    logic [31:0] gap;
    gap = b - a;
    return gap < 32'h8000_0000;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // move the queue head into the staged slot, or leave the slot empty
  task automatic stage_head();
    if (alarm_count == 0) begin
      staged_valid = 1'b0;
    end else begin
      staged_alarm = model_queue[0];
      staged_valid = 1'b1;
      for (int i = 1; i < alarm_count; i++) model_queue[i-1] = model_queue[i];
      alarm_count--;
    end
  endtask

  task automatic advance_alarm_model(alarm_cmd_t c);
    alarm_entry_t  e;
    alarm_result_t r;
    int            pos;
    int            fired;
    if (c.action == ACT_INSERT) begin
      r = '{kind: KIND_FULL, fired_delay: 16'h0, fired_tag: 16'h0, last: 1'b1};
      if (alarm_count < QUEUE_DEPTH) begin
        e.expiry = now_ticks + {16'h0, c.delay_seconds};
        e.delay  = c.delay_seconds;
        e.tag    = c.tag;
        pos = alarm_count;
        // newest goes ahead of equal expiries
        for (int i = 0; i < alarm_count; i++) begin
          if (is_due(e.expiry, model_queue[i].expiry)) begin
            pos = i;
            break;
          end
        end
        for (int i = alarm_count; i > pos; i--) model_queue[i] = model_queue[i-1];
        model_queue[pos] = e;
        alarm_count++;
        r.kind = KIND_ACCEPTED;
      end
      predicted_outcomes.push_back(r);
    end else begin
      fired = 0;
      now_ticks = now_ticks + 32'd1;
      if (!staged_valid) stage_head();
      while (staged_valid && is_due(staged_alarm.expiry, now_ticks)) begin
        r = '{kind: KIND_FIRED, fired_delay: staged_alarm.delay,
              fired_tag: staged_alarm.tag, last: 1'b0};
        predicted_outcomes.push_back(r);
        fired++;
        stage_head();
      end
      if (fired > 0) begin
        r = predicted_outcomes.pop_back();
        r.last = 1'b1;
        predicted_outcomes.push_back(r);
      end
    end
  endtask

  always @(posedge clk) begin
    alarm_result_t want;
    if (rst) begin
      now_ticks    = '0;
      alarm_count  = 0;
      staged_valid = 1'b0;
      predicted_outcomes.delete();
    end else begin
      if (result_valid) begin
        if (predicted_outcomes.size() == 0) begin
          report_mismatch("unexpected result, tag", result.fired_tag, 16'h0);
        end else begin
          want = predicted_outcomes.pop_front();
          if (result.kind != want.kind)
            report_mismatch("kind", 16'(result.kind), 16'(want.kind));
          if (result.fired_delay != want.fired_delay)
            report_mismatch("fired_delay", result.fired_delay, want.fired_delay);
          if (result.fired_tag != want.fired_tag)
            report_mismatch("fired_tag", result.fired_tag, want.fired_tag);
          if (result.last != want.last)
            report_mismatch("last", 16'(result.last), 16'(want.last));
        end
      end
      if (start && !busy) advance_alarm_model(cmd);
    end
    pending_results <= predicted_outcomes.size();
  end

endmodule

// ===== tb/tb_sorted_alarm_queue_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_alarm_queue_unit
// Drives inserts and ticks into the sorted alarm queue with random gaps;
// a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_sorted_alarm_queue_unit;
  import saq_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 75;
  localparam int DRAIN_CYCLES   = 100;

  logic          clk;
  logic          rst;
  logic          start;
  logic          busy;
  alarm_cmd_t    cmd;
  logic          result_valid;
  alarm_result_t result;
  int unsigned   mismatch_total;
  int unsigned   outstanding;
  int unsigned   quiet_cycles = 0;
  bit            no_gaps;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  sorted_alarm_queue_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .cmd          (cmd),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
  );

  saq_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .cmd             (cmd),
    .result_valid    (result_valid),
    .result          (result),
    .error_count     (mismatch_total),
    .pending_results (outstanding)
  );

  always @(posedge clk) begin
    if ((start && !busy) || result_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  // start stays high across back-to-back transactions
  task automatic issue(action_e act, logic [15:0] dly, logic [15:0] tg);
    int r;
    int gap;
    cmd   <= '{action: act, delay_seconds: dly, tag: tg};
    start <= 1'b1;
    do @(posedge clk); while (busy);
    r = $urandom_range(0, 99);
    gap = 0;
    if (!no_gaps) begin
      if (r >= 95) gap = $urandom_range(15, 60);
      else if (r >= 65) gap = $urandom_range(1, 4);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    int sent;
    int n;
    rst   <= 1'b1;
    start <= 1'b0;
    cmd   <= '0;
    no_gaps = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // two equal expiries fire newest first, a later one stays staged
    issue(ACT_INSERT, 16'h0000, 16'hFFFF);
    issue(ACT_INSERT, 16'h0000, 16'h0000);
    issue(ACT_INSERT, 16'h0003, 16'h1234);
    issue(ACT_TICK, 16'hFFFF, 16'hFFFF);
    // fill the table; staged slot does not count
    no_gaps = 1'b0;
    for (int i = 0; i < QUEUE_DEPTH; i++)
      issue(ACT_INSERT, (i % 5 == 0) ? 16'h0001 : 16'h0002, 16'(16'hA000 + i));
    issue(ACT_INSERT, 16'h0001, 16'h5555);
    // quiet tick, then the staged alarm and the whole table fire at once
    issue(ACT_TICK, 16'h0, 16'h0);
    issue(ACT_TICK, 16'h0, 16'h0);
    issue(ACT_TICK, 16'h0, 16'h0);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent % 16 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      n = $urandom_range(1, 6);
      if ($urandom_range(0, 1)) begin
        repeat (n) issue(ACT_INSERT, 16'($urandom_range(0, 12)), 16'($urandom));
      end else begin
        repeat (n) issue(ACT_TICK, 16'($urandom), 16'($urandom));
      end
      sent += n;
    end

    // long delays block the staged slot, so they come last
    issue(ACT_INSERT, 16'hFFFF, 16'h0000);
    repeat (10) begin
      if ($urandom_range(0, 1)) issue(ACT_INSERT, 16'($urandom), 16'($urandom));
      else issue(ACT_TICK, 16'($urandom), 16'($urandom));
    end

    start <= 1'b0;
    while (outstanding != 0 || busy) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_total == 0 && outstanding == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
